@@ hw/rtl/odbw_pkg.sv @@
// odbw_pkg: shared widths, register indexes, reset values and dither matrices
// for the ordered black/white dither core. No dependencies.
package odbw_pkg;

  localparam int PIXEL_W        = 8;
  localparam int PIXEL_BITS_DEF = 8;
  localparam int CFG_W          = 8;
  localparam int IDX_W          = 2;
  localparam int MSIZE_W        = 3;
  localparam int PHASE_W        = 2;
  localparam int ENTRY_W        = 4;

  localparam logic [IDX_W-1:0] REG_MAX_LEVEL   = 2'd0;
  localparam logic [IDX_W-1:0] REG_MATRIX_SIZE = 2'd1;

  localparam logic [PIXEL_W-1:0] MAX_LEVEL_RST   = 8'd255;
  localparam logic [MSIZE_W-1:0] MATRIX_SIZE_RST = 3'd4;

  localparam logic [MSIZE_W-1:0] K2 = 3'd2;
  localparam logic [MSIZE_W-1:0] K3 = 3'd3;
  localparam logic [MSIZE_W-1:0] K4 = 3'd4;

  typedef logic [ENTRY_W-1:0] entry_t;

  localparam entry_t DM2 [2][2] = '{'{4'd0, 4'd2}, '{4'd3, 4'd1}};
  localparam entry_t DM3 [3][3] = '{'{4'd2, 4'd6, 4'd4},
                                    '{4'd5, 4'd0, 4'd1},
                                    '{4'd8, 4'd3, 4'd7}};
  localparam entry_t DM4 [4][4] = '{'{4'd0,  4'd8,  4'd2,  4'd10},
                                    '{4'd12, 4'd4,  4'd14, 4'd6},
                                    '{4'd3,  4'd11, 4'd1,  4'd9},
                                    '{4'd15, 4'd7,  4'd13, 4'd5}};

  // effective matrix size: below two acts as 2, above four as 4
  function automatic logic [MSIZE_W-1:0] eff_k(input logic [MSIZE_W-1:0] ms);
    logic [MSIZE_W-1:0] k;
    if (ms < K2)      k = K2;
    else if (ms > K4) k = K4;
    else              k = ms;
    return k;
  endfunction

  function automatic entry_t dither_entry(input logic [MSIZE_W-1:0] k,
                                          input logic [PHASE_W-1:0] r,
                                          input logic [PHASE_W-1:0] c);
    logic [1:0] r3;
    logic [1:0] c3;
    entry_t     e;
    r3 = (r < 2'd3) ? r : 2'd2;
    c3 = (c < 2'd3) ? c : 2'd2;
    if (k == K2)      e = DM2[r[0]][c[0]];
    else if (k == K3) e = DM3[r3][c3];
    else              e = DM4[r][c];
    return e;
  endfunction

endpackage

@@ hw/rtl/ordered_dither_bw_core.sv @@
// ordered_dither_bw_core: ordered dither of gray pixels to black/white with a
// 2x2, 3x3 or 4x4 matrix and a one-bit-per-cycle restoring divider.
// Depends on odbw_pkg.
// An accepted word passes through the divide state, and the hold state while
//   out_stall blocks the output, before its result enters the output register.
//   Meanwhile no word is taken; the divider gives one quotient bit per cycle.
// in_stall is high from acceptance until the divide is done and its result has
//   entered the output register.
// Reset (synchronous, rst high): max_level 255, matrix_size 4, phases zero,
//   sequencer idle, no output word pending.
module ordered_dither_bw_core #(
  parameter int PIXEL_BITS = odbw_pkg::PIXEL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [odbw_pkg::IDX_W-1:0]   cfg_index,
  input  logic [odbw_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [odbw_pkg::PIXEL_W-1:0] pixel,
  input  logic                         row_end,
  input  logic                         frame_end,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         white
);
  import odbw_pkg::*;

  localparam int PB   = (PIXEL_BITS < PIXEL_W) ? PIXEL_BITS : PIXEL_W;
  localparam int CW   = $clog2(PB) + 1;
  localparam int CMPW = (PB > ENTRY_W) ? PB : ENTRY_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]          state;
  logic [PIXEL_W-1:0]  max_level;
  logic [MSIZE_W-1:0]  matrix_size;
  logic [PHASE_W-1:0]  row_phase;
  logic [PHASE_W-1:0]  column_phase;
  logic [CW-1:0]       cnt;
  logic [PB-1:0]       dividend;
  logic [PB-1:0]       quot;
  logic [PIXEL_W-1:0]  rem;
  logic [PIXEL_W-1:0]  thr;
  entry_t              entry;

  logic [MSIZE_W-1:0]  k_eff;
  logic [13:0]         prod9;
  logic [PIXEL_W-1:0]  thr_raw;
  logic [PIXEL_W-1:0]  thr_next;
  logic [PIXEL_W:0]    trial;
  logic                q_bit;
  logic [PIXEL_W-1:0]  rem_next;
  logic [PB-1:0]       quot_next;
  logic                white_next;
  logic                in_take;
  logic                out_free;
  logic                out_load;
  logic                last_step;
  logic [PHASE_W-1:0]  row_inc;
  logic [PHASE_W-1:0]  col_inc;

  assign k_eff = eff_k(matrix_size);
  assign prod9 = {6'd0, max_level} * 14'd57;

  // /4 and /16 are shifts, /9 is x*57>>9 (exact for 8-bit x)
  always_comb begin
    unique case (k_eff)
      K2:      thr_raw = {2'd0, max_level[7:2]};
      K3:      thr_raw = {3'd0, prod9[13:9]};
      default: thr_raw = {4'd0, max_level[7:4]};
    endcase
    thr_next = (thr_raw == '0) ? 8'd1 : thr_raw;
  end

  assign trial     = {1'b0, rem[PIXEL_W-2:0], dividend[PB-1]};
  assign q_bit     = (trial >= {1'b0, thr});
  assign rem_next  = q_bit ? PIXEL_W'(trial - {1'b0, thr}) : trial[PIXEL_W-1:0];
  assign quot_next = PB'({quot, q_bit});
  assign white_next = CMPW'(quot_next) > CMPW'(entry);

  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign last_step = (state == ST_DIV) && (cnt == CW'(PB - 1));
  assign out_load  = (last_step || (state == ST_HOLD)) && out_free;

  assign row_inc = (3'(row_phase) + 3'd1 >= k_eff) ? '0 : row_phase + 2'd1;
  assign col_inc = (3'(column_phase) + 3'd1 >= k_eff) ? '0 : column_phase + 2'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      max_level    <= MAX_LEVEL_RST;
      matrix_size  <= MATRIX_SIZE_RST;
      row_phase    <= '0;
      column_phase <= '0;
      cnt          <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_LEVEL: max_level <= cfg_data;
          REG_MATRIX_SIZE: begin
            matrix_size  <= cfg_data[MSIZE_W-1:0];
            row_phase    <= '0;
            column_phase <= '0;
          end
          default: ;
        endcase
      end

      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            state <= ST_DIV;
            cnt   <= '0;
            if (frame_end) begin
              row_phase    <= '0;
              column_phase <= '0;
            end else if (row_end) begin
              row_phase    <= row_inc;
              column_phase <= '0;
            end else begin
              column_phase <= col_inc;
            end
          end
        end
        ST_DIV: begin
          cnt <= cnt + CW'(1);
          if (last_step) begin
            if (out_free) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_take) begin
      dividend <= pixel[PB-1:0];
      quot     <= '0;
      rem      <= '0;
      thr      <= thr_next;
      entry    <= dither_entry(k_eff, row_phase, column_phase);
    end else if (state == ST_DIV) begin
      dividend <= dividend << 1;
      quot     <= quot_next;
      rem      <= rem_next;
      if (last_step && out_free) white <= white_next;
    end else if (state == ST_HOLD && out_free) begin
      white <= CMPW'(quot) > CMPW'(entry);
    end
  end

  a_take_starts_div: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == ST_DIV) && (cnt == '0))
    else $error("accepted word did not start divide");

  a_done_loads_out: assert property (@(posedge clk) disable iff (rst)
    last_step && out_free |=> out_valid && (state == ST_IDLE))
    else $error("finished divide did not load output");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    (3'(row_phase) < k_eff) && (3'(column_phase) < k_eff))
    else $error("phase reached matrix size");

  a_thr_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (thr != '0))
    else $error("zero divisor");

  a_rem_below_thr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < thr))
    else $error("remainder not below divisor");

endmodule
